FILE: rtl/core/crc_pkg.sv
// ----------------------------------------------------------------------------
// crc_pkg
// Widths, codes and stage item types shared by the column residual
// correlation block.
// ----------------------------------------------------------------------------
package crc_pkg;

    localparam int MAX_ROWS  = 1024;
    localparam int ADDR_W    = $clog2(MAX_ROWS);
    localparam int ROW_W     = 10;
    localparam int VAL_W     = 32;
    localparam int COL_W     = 16;
    localparam int SUM_W     = 48;
    localparam int ACC_W     = 64;
    localparam int FRAC_W    = 16;
    localparam int HI_W      = SUM_W - FRAC_W;
    localparam int PL_W      = VAL_W + FRAC_W + 1;
    localparam int RND_ACC_W = ACC_W - FRAC_W + 1;
    localparam int RND_PL_W  = PL_W - FRAC_W + 1;
    localparam int TERM_W    = ACC_W + 1;
    localparam int DIFF_W    = TERM_W + 1;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_MATRIX = 1'b1;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // matrix item after the multipliers
    typedef struct packed {
        logic                      valid;
        logic                      last;
        logic [COL_W-1:0]          col;
        logic signed [ACC_W-1:0]   prod;
        logic signed [ACC_W-1:0]   cen_hi;
        logic signed [PL_W-1:0]    cen_lo;
    } mac_item_t;

    // finished column before rounding and clipping
    typedef struct packed {
        logic                      valid;
        logic [COL_W-1:0]          col;
        logic signed [ACC_W-1:0]   acc;
        logic                      ovf;
        logic signed [TERM_W-1:0]  term;
    } fin_item_t;

endpackage

FILE: rtl/core/crc_in_if.sv
// ----------------------------------------------------------------------------
// crc_in_if
// Input item channel: residual loads and matrix column elements.
// ----------------------------------------------------------------------------
interface crc_in_if;
    import crc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     action;
    logic [ROW_W-1:0]         row_index;
    logic signed [VAL_W-1:0]  element_value;
    logic [COL_W-1:0]         column_index;
    logic signed [VAL_W-1:0]  column_offset;
    logic                     last_in_column;

    modport source (
        output valid, action, row_index, element_value, column_index,
               column_offset, last_in_column,
        input  ready
    );

    modport sink (
        input  valid, action, row_index, element_value, column_index,
               column_offset, last_in_column,
        output ready
    );
endinterface

FILE: rtl/core/crc_out_if.sv
// ----------------------------------------------------------------------------
// crc_out_if
// Result item channel: one correlation per finished column.
// ----------------------------------------------------------------------------
interface crc_out_if;
    import crc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [COL_W-1:0]         result_column;
    logic signed [SUM_W-1:0]  correlation;
    logic                     saturated;

    modport source (
        output valid, result_column, correlation, saturated,
        input  ready
    );

    modport sink (
        input  valid, result_column, correlation, saturated,
        output ready
    );
endinterface

FILE: rtl/core/crc_ram.sv
// ----------------------------------------------------------------------------
// crc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module crc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/crc_front.sv
// ----------------------------------------------------------------------------
// crc_front
// Input stage: residual store and running residual sum, store lookup and
// the element and centering multipliers.
// ----------------------------------------------------------------------------
module crc_front (
    input  logic               clk,
    input  logic               rst_n,
    crc_in_if.sink             elem,
    output crc_pkg::mac_item_t mac,
    input  logic               mac_ready
);
    import crc_pkg::*;

    typedef struct packed {
        logic                     valid;
        logic                     action;
        logic                     row_zero;
        logic                     in_range;
        logic signed [VAL_W-1:0]  val;
        logic [COL_W-1:0]         col;
        logic signed [VAL_W-1:0]  off;
        logic                     last;
    } s1_item_t;

    s1_item_t                  s1_reg;
    s1_item_t                  s1_next;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [SUM_W-1:0]   sum_next;
    logic signed [SUM_W-1:0]   sum_base;
    logic signed [SUM_W:0]     sum_add;
    logic                      s1_load;
    logic                      s1_go;
    logic                      s1_free;
    logic                      accept;
    logic                      in_range_in;
    logic signed [VAL_W-1:0]   rd_data;
    logic signed [VAL_W-1:0]   s1_val;
    logic signed [VAL_W-1:0]   s1_off;
    logic signed [HI_W-1:0]    hi_op;
    logic signed [FRAC_W:0]    lo_op;
    logic signed [ACC_W-1:0]   prod_full;
    logic signed [ACC_W-1:0]   cen_hi_full;
    logic signed [PL_W-1:0]    cen_lo_full;

    assign s1_load  = (s1_reg.action == ACT_LOAD);
    assign s1_go    = s1_reg.valid && (s1_load || mac_ready);
    assign s1_free  = !s1_reg.valid || s1_go;
    assign elem.ready = s1_free;
    assign accept   = elem.valid && elem.ready;

    assign in_range_in = (32'(elem.row_index) < MAX_ROWS);

    crc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_ROWS)
    ) u_store (
        .clk   (clk),
        .we    (accept && (elem.action == ACT_LOAD) && in_range_in),
        .waddr (ADDR_W'(elem.row_index)),
        .wdata (elem.element_value),
        .re    (accept && (elem.action == ACT_MATRIX)),
        .raddr (ADDR_W'(elem.row_index)),
        .rdata (rd_data)
    );

    always_comb
    begin
        s1_next.valid    = elem.valid;
        s1_next.action   = elem.action;
        s1_next.row_zero = (elem.row_index == '0);
        s1_next.in_range = in_range_in;
        s1_next.val      = elem.element_value;
        s1_next.col      = elem.column_index;
        s1_next.off      = elem.column_offset;
        s1_next.last     = elem.last_in_column;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else if (s1_free)
        begin
            s1_reg <= s1_next;
        end
    end

    // residual sum, restarted by a load at row zero
    assign s1_val   = s1_reg.val;
    assign s1_off   = s1_reg.off;
    assign sum_base = s1_reg.row_zero ? '0 : sum_reg;
    assign sum_add  = (SUM_W+1)'(sum_base) + (SUM_W+1)'(s1_val);

    always_comb
    begin
        if (sum_add[SUM_W] != sum_add[SUM_W-1])
        begin
            sum_next = sum_add[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum_next = sum_add[SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (s1_go && s1_load && s1_reg.in_range)
        begin
            sum_reg <= sum_next;
        end
    end

    // centering term split into integer and fraction parts of the sum
    assign hi_op       = sum_reg[SUM_W-1:FRAC_W];
    assign lo_op       = {1'b0, sum_reg[FRAC_W-1:0]};
    assign prod_full   = s1_val * rd_data;
    assign cen_hi_full = s1_off * hi_op;
    assign cen_lo_full = s1_off * lo_op;

    always_comb
    begin
        mac.valid  = s1_reg.valid && !s1_load;
        mac.last   = s1_reg.last;
        mac.col    = s1_reg.col;
        mac.prod   = s1_reg.in_range ? prod_full : '0;
        mac.cen_hi = cen_hi_full;
        mac.cen_lo = cen_lo_full;
    end

    a_row_zero_restart: assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_go && s1_load && s1_reg.in_range && s1_reg.row_zero
        |=> sum_reg == SUM_W'($past(s1_val))
    ) else $error("load at row zero did not restart the residual sum");

endmodule

FILE: rtl/core/crc_accum.sv
// ----------------------------------------------------------------------------
// crc_accum
// Saturating column accumulator and centering term.
// ----------------------------------------------------------------------------
module crc_accum (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               apply_centering,
    input  crc_pkg::mac_item_t mac,
    output logic               mac_ready,
    output crc_pkg::fin_item_t fin,
    input  logic               fin_ready
);
    import crc_pkg::*;

    mac_item_t                  s2_reg;
    logic                       s2_go;
    logic                       s2_free;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic                       ovf_reg;
    logic                       ovf_next;
    logic signed [ACC_W:0]      acc_wide;
    logic                       clip_now;
    logic signed [ACC_W-1:0]    hi_s;
    logic signed [PL_W-1:0]     lo_s;
    logic signed [RND_PL_W-1:0] rnd_lo;
    logic signed [TERM_W-1:0]   term_full;

    assign s2_go     = s2_reg.valid && (!s2_reg.last || fin_ready);
    assign s2_free   = !s2_reg.valid || s2_go;
    assign mac_ready = s2_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
        end
        else if (s2_free)
        begin
            s2_reg <= mac;
        end
    end

    assign acc_wide = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(s2_reg.prod);
    assign clip_now = acc_wide[ACC_W] ^ acc_wide[ACC_W-1];

    always_comb
    begin
        if (clip_now)
        begin
            acc_next = acc_wide[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            acc_next = acc_wide[ACC_W-1:0];
        end
        ovf_next = ovf_reg || clip_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (s2_go)
        begin
            if (s2_reg.last)
            begin
                acc_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else
            begin
                acc_reg <= acc_next;
                ovf_reg <= ovf_next;
            end
        end
    end

    // offset times residual sum, rounded to q49.16
    assign hi_s      = s2_reg.cen_hi;
    assign lo_s      = s2_reg.cen_lo;
    assign rnd_lo    = RND_PL_W'($signed(lo_s[PL_W-1:FRAC_W]))
                     + RND_PL_W'({1'b0, lo_s[FRAC_W-1]});
    assign term_full = TERM_W'(hi_s) + TERM_W'(rnd_lo);

    always_comb
    begin
        fin.valid = s2_reg.valid && s2_reg.last;
        fin.col   = s2_reg.col;
        fin.acc   = acc_next;
        fin.ovf   = ovf_next;
        fin.term  = apply_centering ? term_full : '0;
    end

    a_column_clear: assert property (
        @(posedge clk) disable iff (!rst_n)
        s2_go && s2_reg.last |=> (acc_reg == '0) && !ovf_reg
    ) else $error("accumulator not cleared after a column result");

    a_last_held: assert property (
        @(posedge clk) disable iff (!rst_n)
        fin.valid && !fin_ready |=> s2_reg.valid && s2_reg.last && $stable(acc_reg)
    ) else $error("stalled last item lost or accumulator moved");

endmodule

FILE: rtl/core/crc_result.sv
// ----------------------------------------------------------------------------
// crc_result
// Rounding, centering subtraction, 48-bit clipping and the result register.
// ----------------------------------------------------------------------------
module crc_result (
    input  logic               clk,
    input  logic               rst_n,
    input  crc_pkg::fin_item_t fin,
    output logic               fin_ready,
    crc_out_if.source          result
);
    import crc_pkg::*;

    fin_item_t                   s3_reg;
    logic                        s3_go;
    logic                        s3_free;
    logic                        out_free;
    logic                        out_v_reg;
    logic [COL_W-1:0]            col_reg;
    logic signed [SUM_W-1:0]     corr_reg;
    logic signed [SUM_W-1:0]     corr_next;
    logic                        sat_reg;
    logic                        sat_next;
    logic signed [ACC_W-1:0]     acc_s;
    logic signed [RND_ACC_W-1:0] rnd_acc;
    logic signed [DIFF_W-1:0]    diff;

    assign out_free  = !out_v_reg || result.ready;
    assign s3_go     = s3_reg.valid && out_free;
    assign s3_free   = !s3_reg.valid || s3_go;
    assign fin_ready = s3_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_reg <= '0;
        end
        else if (s3_free)
        begin
            s3_reg <= fin;
        end
    end

    assign acc_s   = s3_reg.acc;
    assign rnd_acc = RND_ACC_W'($signed(acc_s[ACC_W-1:FRAC_W]))
                   + RND_ACC_W'({1'b0, acc_s[FRAC_W-1]});
    assign diff    = DIFF_W'(rnd_acc) - DIFF_W'(s3_reg.term);

    always_comb
    begin
        sat_next = s3_reg.ovf;
        if (diff > DIFF_W'(SUM_MAX))
        begin
            corr_next = SUM_MAX;
            sat_next  = 1'b1;
        end
        else if (diff < DIFF_W'(SUM_MIN))
        begin
            corr_next = SUM_MIN;
            sat_next  = 1'b1;
        end
        else
        begin
            corr_next = diff[SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (s3_go)
        begin
            out_v_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_go)
        begin
            col_reg  <= s3_reg.col;
            corr_reg <= corr_next;
            sat_reg  <= sat_next;
        end
    end

    assign result.valid         = out_v_reg;
    assign result.result_column = col_reg;
    assign result.correlation   = corr_reg;
    assign result.saturated     = sat_reg;

    a_s3_held: assert property (
        @(posedge clk) disable iff (!rst_n)
        s3_reg.valid && !out_free |=> s3_reg.valid && $stable(s3_reg.acc)
    ) else $error("waiting column lost while result register busy");

    a_out_drains: assert property (
        @(posedge clk) disable iff (!rst_n)
        result.valid && result.ready && !s3_reg.valid |=> !result.valid
    ) else $error("result repeated after it was taken");

endmodule

FILE: rtl/core/column_residual_correlation.sv
// ----------------------------------------------------------------------------
// column_residual_correlation
// Dot product of streamed matrix columns with a stored residual vector,
// with optional centering: signed q16.16 operands, signed q32.16 result.
// ----------------------------------------------------------------------------
// One item is taken every clock cycle when the result side keeps up. A
// residual load writes the 1024-entry store and updates the residual sum; a
// matrix element reads the store, is multiplied and added to a saturating
// 64-bit accumulator. The element marked last in its column gives a result
// after store read, multiply, accumulate, round and clip via s1, s2, s3 and
// the result register. The single store port pair and the accumulate loop
// set this rate. Only a column's last element can wait on the result side;
// loads still pass, other elements wait behind it. Store entries have no
// reset and must be loaded before a matrix element reads them. The centering
// flag must be written only while no item is in flight; nothing checks it.
// ----------------------------------------------------------------------------
module column_residual_correlation (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_data,
    crc_in_if.sink     elem,
    crc_out_if.source  result
);
    import crc_pkg::*;

    logic      apply_centering_reg;
    mac_item_t mac;
    logic      mac_ready;
    fin_item_t fin;
    logic      fin_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            apply_centering_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            apply_centering_reg <= cfg_data;
        end
    end

    crc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .elem      (elem),
        .mac       (mac),
        .mac_ready (mac_ready)
    );

    crc_accum u_accum (
        .clk             (clk),
        .rst_n           (rst_n),
        .apply_centering (apply_centering_reg),
        .mac             (mac),
        .mac_ready       (mac_ready),
        .fin             (fin),
        .fin_ready       (fin_ready)
    );

    crc_result u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .fin       (fin),
        .fin_ready (fin_ready),
        .result    (result)
    );

endmodule

FILE: tb/sv/tb_column_residual_correlation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_column_residual_correlation
// Self-checking bench for the column residual correlation block. A directed
// table of residual loads and matrix columns comes first, then random load
// and column sequences under several idle and stall patterns. Results are
// compared in order against the table or a q16.16 dot product in the bench.
// ----------------------------------------------------------------------------
module tb_column_residual_correlation;
    import crc_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int SETTLE       = 8;
    localparam int PHASE_ITEMS  = 475;
    localparam int REPORT_LIMIT = 10;
    localparam int WIDE_W       = 128;

    typedef struct packed {
        logic              action;
        logic [ROW_W-1:0]  row;
        logic [VAL_W-1:0]  value;
        logic [COL_W-1:0]  col;
        logic [VAL_W-1:0]  offset;
        logic              last;
    } elem_item_t;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [SUM_W-1:0]  corr;
        logic              sat;
    } corr_result_t;

    typedef struct packed {
        elem_item_t    item;
        logic          typed;
        corr_result_t  want;
    } plan_row_t;

    localparam corr_result_t NO_CHECK = '0;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_data;

    crc_in_if  elem_bus ();
    crc_out_if result_bus ();

    column_residual_correlation dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .elem     (elem_bus),
        .result   (result_bus)
    );

    always #10 clk = ~clk;

    // bench copy of the block state
    logic [VAL_W-1:0]         residual_mem [MAX_ROWS];
    logic signed [SUM_W-1:0]  res_sum;
    logic signed [ACC_W-1:0]  col_acc;
    bit                       acc_clipped;
    bit                       centering_on;

    bit                       row_written [MAX_ROWS];
    int                       written_rows [$];
    corr_result_t             pending_results [$];

    int idle_pct;
    int stall_pct;
    int items_sent;
    int mismatch_count;
    int cycle_count = 0;

    plan_row_t plan [23] = '{
        '{'{ACT_LOAD,   10'd0,    32'h0001_0000, 16'h0000, 32'h0000_0000, 1'b0}, 1'b0, NO_CHECK},
        '{'{ACT_LOAD,   10'd1,    32'h7FFF_FFFF, 16'h0000, 32'h0000_0000, 1'b0}, 1'b0, NO_CHECK},
        '{'{ACT_LOAD,   10'd2,    32'h8000_0000, 16'h0000, 32'h0000_0000, 1'b0}, 1'b0, NO_CHECK},
        '{'{ACT_LOAD,   10'd3,    32'hFFFF_FFFF, 16'h0000, 32'h0000_0000, 1'b0}, 1'b0, NO_CHECK},
        '{'{ACT_LOAD,   10'd1023, 32'h0002_0000, 16'hFFFF, 32'hFFFF_FFFF, 1'b1}, 1'b0, NO_CHECK},
        '{'{ACT_LOAD,   10'd682,  32'h7FFF_FFFF, 16'h0000, 32'h0000_0000, 1'b0}, 1'b0, NO_CHECK},
        '{'{ACT_LOAD,   10'd341,  32'h8000_0000, 16'h0000, 32'h0000_0000, 1'b0}, 1'b0, NO_CHECK},
        '{'{ACT_MATRIX, 10'd0,    32'h0001_0000, 16'h0000, 32'h0000_0000, 1'b1}, 1'b1,
          '{16'h0000, 48'h0000_0001_0000, 1'b0}},
        '{'{ACT_MATRIX, 10'd1023, 32'h0000_0000, 16'hFFFF, 32'h7FFF_FFFF, 1'b1}, 1'b1,
          '{16'hFFFF, 48'h0, 1'b0}},
        '{'{ACT_MATRIX, 10'd2,    32'h8000_0000, 16'h1234, 32'h8000_0000, 1'b0}, 1'b0, NO_CHECK},
        '{'{ACT_MATRIX, 10'd2,    32'h8000_0000, 16'h1234, 32'h8000_0000, 1'b0}, 1'b0, NO_CHECK},
        '{'{ACT_MATRIX, 10'd2,    32'h8000_0000, 16'h1234, 32'h8000_0000, 1'b1}, 1'b1,
          '{16'h1234, SUM_MAX, 1'b1}},
        '{'{ACT_MATRIX, 10'd1,    32'h8000_0000, 16'h5678, 32'h0000_0000, 1'b0}, 1'b0, NO_CHECK},
        '{'{ACT_MATRIX, 10'd1,    32'h8000_0000, 16'h5678, 32'h0000_0000, 1'b0}, 1'b0, NO_CHECK},
        '{'{ACT_MATRIX, 10'd1,    32'h8000_0000, 16'h5678, 32'h0000_0000, 1'b1}, 1'b1,
          '{16'h5678, SUM_MIN, 1'b1}},
        '{'{ACT_MATRIX, 10'd3,    32'hFFFF_FFFF, 16'h0001, 32'h0000_0000, 1'b1}, 1'b1,
          '{16'h0001, 48'h0, 1'b0}},
        '{'{ACT_MATRIX, 10'd3,    32'hFFFF_8000, 16'h0002, 32'h0001_0000, 1'b1}, 1'b0, NO_CHECK},
        '{'{ACT_MATRIX, 10'd0,    32'h0001_8000, 16'h0003, 32'h0000_0000, 1'b0}, 1'b0, NO_CHECK},
        '{'{ACT_MATRIX, 10'd1023, 32'hFFFF_0000, 16'h0003, 32'h0000_0000, 1'b0}, 1'b0, NO_CHECK},
        '{'{ACT_MATRIX, 10'd3,    32'h1234_5678, 16'h0003, 32'h0000_0000, 1'b1}, 1'b0, NO_CHECK},
        '{'{ACT_LOAD,   10'd0,    32'hFFFF_0000, 16'h0000, 32'h0000_0000, 1'b0}, 1'b0, NO_CHECK},
        '{'{ACT_MATRIX, 10'd682,  32'h7FFF_FFFF, 16'hAAAA, 32'h0000_0000, 1'b0}, 1'b0, NO_CHECK},
        '{'{ACT_MATRIX, 10'd341,  32'h7FFF_FFFF, 16'h5555, 32'hFFFF_FFFF, 1'b1}, 1'b0, NO_CHECK}
    };

    function automatic logic signed [WIDE_W-1:0] clip_to(input logic signed [WIDE_W-1:0] x,
                                                         input int bits, output bit hit);
        logic signed [WIDE_W-1:0] top;
        logic signed [WIDE_W-1:0] bottom;
        top    = (128'sd1 <<< (bits - 1)) - 128'sd1;
        bottom = -top - 128'sd1;
        hit    = 1'b0;
        if (x > top)
        begin
            hit = 1'b1;
            return top;
        end
        if (x < bottom)
        begin
            hit = 1'b1;
            return bottom;
        end
        return x;
    endfunction

    // q32.32 to q32.16, half an lsb up then floor
    function automatic logic signed [WIDE_W-1:0] round_q16(input logic signed [WIDE_W-1:0] x);
        logic signed [WIDE_W-1:0] r;
        r = x >>> FRAC_W;
        if (x[FRAC_W-1])
            r = r + 128'sd1;
        return r;
    endfunction

    function automatic bit predict_correlation(input elem_item_t it, output corr_result_t res);
        logic signed [WIDE_W-1:0] wide;
        logic signed [WIDE_W-1:0] prod;
        logic signed [WIDE_W-1:0] term;
        bit hit;
        bit clipped;
        res = '0;
        if (it.action == ACT_LOAD)
        begin
            if (it.row == '0)
                res_sum = '0;
            residual_mem[it.row] = it.value;
            wide = WIDE_W'(res_sum);
            wide = wide + WIDE_W'($signed(it.value));
            wide = clip_to(wide, SUM_W, hit);
            res_sum = wide[SUM_W-1:0];
            return 1'b0;
        end
        prod = WIDE_W'($signed(it.value)) * WIDE_W'($signed(residual_mem[it.row]));
        wide = WIDE_W'(col_acc);
        wide = clip_to(wide + prod, ACC_W, hit);
        col_acc = wide[ACC_W-1:0];
        if (hit)
            acc_clipped = 1'b1;
        if (!it.last)
            return 1'b0;
        wide = round_q16(WIDE_W'(col_acc));
        if (centering_on)
        begin
            term = WIDE_W'($signed(it.offset)) * WIDE_W'(res_sum);
            wide = wide - round_q16(term);
        end
        wide = clip_to(wide, SUM_W, hit);
        clipped = acc_clipped | hit;
        res = '{it.col, wide[SUM_W-1:0], clipped};
        col_acc = '0;
        acc_clipped = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            4, 5: return {{12{r[19]}}, r[19:0]};
            default: return r;
        endcase
    endfunction

    function automatic elem_item_t load_item(input int row, input logic [VAL_W-1:0] value);
        elem_item_t it;
        it.action = ACT_LOAD;
        it.row    = row[ROW_W-1:0];
        it.value  = value;
        it.col    = COL_W'($urandom);
        it.offset = $urandom;
        it.last   = 1'($urandom_range(1));
        return it;
    endfunction

    task automatic send_item(input elem_item_t it, input bit typed, input corr_result_t want);
        corr_result_t got;
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            elem_bus.valid <= 1'b0;
        end
        @(negedge clk);
        elem_bus.valid          <= 1'b1;
        elem_bus.action         <= it.action;
        elem_bus.row_index      <= it.row;
        elem_bus.element_value  <= it.value;
        elem_bus.column_index   <= it.col;
        elem_bus.column_offset  <= it.offset;
        elem_bus.last_in_column <= it.last;
        do @(posedge clk); while (elem_bus.ready !== 1'b1);
        items_sent++;
        if (it.action == ACT_LOAD && !row_written[it.row])
        begin
            row_written[it.row] = 1'b1;
            written_rows.push_back(int'(it.row));
        end
        if (predict_correlation(it, got))
            pending_results.push_back(typed ? want : got);
    endtask

    task automatic drain_results();
        @(negedge clk);
        elem_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_centering(input bit on);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= on;
        @(negedge clk);
        cfg_we   <= 1'b0;
        centering_on = on;
    endtask

    // only rows already loaded are read; a few loads may cut into the column
    task automatic send_column(input int len, input bit dense);
        elem_item_t it;
        int start;
        int k;
        start     = $urandom_range(written_rows.size() - 1);
        it.action = ACT_MATRIX;
        it.col    = COL_W'($urandom);
        for (k = 0; k < len; k++)
        begin
            if (k != 0 && $urandom_range(9) == 0)
                send_item(load_item($urandom_range(MAX_ROWS - 1), pick_value()), 1'b0, NO_CHECK);
            if (dense)
                it.row = ROW_W'(written_rows[(start + k) % written_rows.size()]);
            else
                it.row = ROW_W'(written_rows[$urandom_range(written_rows.size() - 1)]);
            it.value  = pick_value();
            it.offset = pick_value();
            it.last   = (k == len - 1);
            send_item(it, 1'b0, NO_CHECK);
        end
    endtask

    task automatic run_random(input int goal);
        int stop_at;
        int kind;
        int len;
        int r;
        stop_at = items_sent + goal;
        while (items_sent < stop_at)
        begin
            kind = $urandom_range(99);
            if (kind < 15)
            begin
                len = $urandom_range(1, 24);
                for (r = 0; r < len; r++)
                    send_item(load_item(r, pick_value()), 1'b0, NO_CHECK);
            end
            else if (kind < 25)
                send_item(load_item($urandom_range(MAX_ROWS - 1), pick_value()), 1'b0, NO_CHECK);
            else if (kind < 27)
                drain_results();
            else
                send_column($urandom_range(1, 8), 1'($urandom_range(1)));
        end
    endtask

    task automatic note_mismatch(input corr_result_t want, input corr_result_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch: col %h/%h corr %h/%h sat %b/%b (expected/actual)",
                     want.col, got.col, want.corr, got.corr, want.sat, got.sat);
    endtask

    always @(negedge clk)
        result_bus.ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin : check_results
        corr_result_t got;
        corr_result_t want;
        if (rst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
        begin
            got = '{result_bus.result_column, result_bus.correlation, result_bus.saturated};
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result: col %h corr %h sat %b",
                             got.col, got.corr, got.sat);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.col !== want.col || got.corr !== want.corr || got.sat !== want.sat)
                    note_mismatch(want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : stimulus
        int i;
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_data                = 1'b0;
        elem_bus.valid          = 1'b0;
        elem_bus.action         = ACT_LOAD;
        elem_bus.row_index      = '0;
        elem_bus.element_value  = '0;
        elem_bus.column_index   = '0;
        elem_bus.column_offset  = '0;
        elem_bus.last_in_column = 1'b0;
        result_bus.ready        = 1'b0;
        res_sum                 = '0;
        col_acc                 = '0;
        acc_clipped             = 1'b0;
        centering_on            = 1'b0;
        items_sent              = 0;
        mismatch_count          = 0;
        idle_pct                = 0;
        stall_pct               = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < $size(plan); i++)
            send_item(plan[i].item, plan[i].typed, plan[i].want);

        set_centering(1'b1);
        run_random(PHASE_ITEMS);

        set_centering(1'b0);
        idle_pct = 82;
        run_random(PHASE_ITEMS);

        set_centering(1'b1);
        idle_pct  = 0;
        stall_pct = 82;
        run_random(PHASE_ITEMS);

        set_centering(1'b0);
        idle_pct  = 25;
        stall_pct = 25;
        run_random(PHASE_ITEMS);

        drain_results();
        repeat (16) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
